@@ rtl/core/ptb_pkg.sv @@
// ptb_pkg: shared constants, types and helper functions for the p-tile binarizer.
// Used by every module of the block except the generic RAM.
package ptb_pkg;

  localparam int MAX_PIXELS = 65536;
  localparam int LEVELS     = 256;

  localparam int PIX_W = 8;
  localparam int PCT_W = 7;
  localparam int THR_W = 8;
  localparam int BIN_W = $clog2(LEVELS);
  localparam int CNT_W = $clog2(MAX_PIXELS + 1);

  localparam logic [PCT_W-1:0] PCT_MAX   = PCT_W'(100);
  localparam logic [PCT_W-1:0] PCT_RESET = PCT_W'(50);

  // quota = floor(total * pct / 100) via reciprocal multiply
  localparam int PROD_W   = CNT_W + PCT_W;
  localparam int RECIP_SH = PROD_W + 7;
  localparam int RECIP_W  = PROD_W + 1;
  localparam int QM_W     = PROD_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << RECIP_SH) + 64'd99) / 64'd100);

  localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(LEVELS - 1);
  localparam logic [THR_W-1:0] THR_NONE = {THR_W{1'b1}};

  localparam int OPQ_DEPTH  = 4;
  localparam int OPQ_AW     = $clog2(OPQ_DEPTH);
  localparam int RESQ_DEPTH = 2;
  localparam int RESQ_AW    = $clog2(RESQ_DEPTH);

  typedef enum logic [1:0] {
    OP_ACC,
    OP_ACC_WALK,
    OP_CLS,
    OP_CLS_CLEAR
  } op_kind_t;

  typedef struct packed {
    op_kind_t         kind;
    logic [PIX_W-1:0] pixel;
    logic [BIN_W-1:0] bin;
  } op_t;

  typedef struct packed {
    logic             binary;
    logic [THR_W-1:0] thr;
    logic             last;
  } res_t;

  typedef struct packed {
    logic walking;
    logic acc_busy;
  } bk_stat_t;

  function automatic logic [BIN_W-1:0] bin_of(input logic [PIX_W-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    if (w >= 32'(LEVELS)) begin
      return LAST_BIN;
    end
    return BIN_W'(w);
  endfunction

  function automatic logic [THR_W-1:0] thr_of(input logic [BIN_W-1:0] b);
    logic [31:0] w;
    w = 32'(b);
    if (w > 32'(THR_NONE)) begin
      return THR_NONE;
    end
    return THR_W'(w);
  endfunction

endpackage

@@ rtl/core/ptb_ram.sv @@
// ptb_ram: generic one-write one-read RAM with registered read data.
// Read during write to the same address returns the old contents. No dependencies.
module ptb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/ptb_front.sv @@
// ptb_front: input side; decodes each word into an operation and queues it.
// Depends on ptb_pkg.
module ptb_front import ptb_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic             req_type,
  input  logic [PIX_W-1:0] pixel,
  input  logic             frame_end,
  output op_t              op,
  output logic             op_valid,
  input  logic             op_take
);

  op_t              q [OPQ_DEPTH];
  op_t              op_in;
  logic [OPQ_AW-1:0] wp, rp;
  logic [OPQ_AW:0]   cnt;
  logic              wr, rd;

  always_comb begin
    op_in.pixel = pixel;
    op_in.bin   = bin_of(pixel);
    unique case ({req_type, frame_end})
      2'b00:   op_in.kind = OP_ACC;
      2'b01:   op_in.kind = OP_ACC_WALK;
      2'b10:   op_in.kind = OP_CLS;
      default: op_in.kind = OP_CLS_CLEAR;
    endcase
  end

  assign full     = (cnt == (OPQ_AW+1)'(OPQ_DEPTH));
  assign op_valid = (cnt != '0);
  assign op       = q[rp];
  assign wr       = push && !full;
  assign rd       = op_take && op_valid;

  always_ff @(posedge clk) begin
    if (wr) begin
      q[wp] <= op_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (wr) begin
        wp <= wp + 1'b1;
      end
      if (rd) begin
        rp <= rp + 1'b1;
      end
      case ({wr, rd})
        2'b10:   cnt <= cnt + 1'b1;
        2'b01:   cnt <= cnt - 1'b1;
        default: cnt <= cnt;
      endcase
    end
  end

endmodule

@@ rtl/core/ptb_back.sv @@
// ptb_back: executes queued operations: histogram update, quota and bin walk,
// pixel classification and frame clear. Depends on ptb_pkg and ptb_ram.
module ptb_back import ptb_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [PCT_W-1:0] black_percent,
  input  op_t              op,
  input  logic             op_valid,
  output logic             op_take,
  output logic             res_push,
  output res_t             res,
  input  logic             res_full,
  output bk_stat_t         stat
);

  typedef enum logic [3:0] {
    ST_RUN    = 4'b0001,
    ST_QMUL   = 4'b0010,
    ST_QSCALE = 4'b0100,
    ST_WALK   = 4'b1000
  } bk_state_t;

  bk_state_t         state, state_next;
  logic [CNT_W-1:0]  total;
  logic [LEVELS-1:0] valid;
  logic [THR_W-1:0]  threshold;

  // histogram read-modify-write pipe
  logic              s2_valid;
  logic [BIN_W-1:0]  s2_bin;
  logic              w_valid;
  logic [BIN_W-1:0]  w_bin;
  logic [CNT_W-1:0]  w_data;
  logic [CNT_W-1:0]  old_cnt;

  logic              ram_we;
  logic [BIN_W-1:0]  ram_waddr, ram_raddr;
  logic [CNT_W-1:0]  ram_wdata, ram_rdata;

  // quota and walk
  logic [PCT_W-1:0]  pct;
  logic [PROD_W-1:0] prod;
  logic [QM_W-1:0]   qm;
  logic [CNT_W-1:0]  quota;
  logic [BIN_W:0]    wcnt;
  logic              wmore;
  logic              rd_pend;
  logic [BIN_W-1:0]  rd_bin;
  logic [CNT_W-1:0]  running;
  logic [CNT_W-1:0]  bin_val;
  logic [CNT_W:0]    run_sum;
  logic              hit;

  logic              is_acc, take, counted, clear;

  assign is_acc  = (op.kind == OP_ACC) || (op.kind == OP_ACC_WALK);
  assign take    = (state == ST_RUN) && op_valid && (is_acc || !res_full);
  assign counted = take && is_acc && (total < CNT_W'(MAX_PIXELS));
  assign clear   = take && (op.kind == OP_CLS_CLEAR);
  assign op_take = take;

  assign res_push   = take && !is_acc;
  assign res.binary = (op.pixel > threshold);
  assign res.thr    = threshold;
  assign res.last   = (op.kind == OP_CLS_CLEAR);

  // forward last cycle's write: the RAM returned the old count for it
  always_comb begin
    if (w_valid && (w_bin == s2_bin)) begin
      old_cnt = w_data;
    end else if (valid[s2_bin]) begin
      old_cnt = ram_rdata;
    end else begin
      old_cnt = '0;
    end
  end

  assign ram_we    = s2_valid;
  assign ram_waddr = s2_bin;
  assign ram_wdata = old_cnt + 1'b1;
  assign ram_raddr = (state == ST_WALK) ? wcnt[BIN_W-1:0] : op.bin;

  ptb_ram #(.WIDTH(CNT_W), .DEPTH(LEVELS)) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign pct     = (black_percent > PCT_MAX) ? PCT_MAX : black_percent;
  assign quota   = qm[RECIP_SH +: CNT_W];
  assign wmore   = (wcnt < (BIN_W+1)'(LEVELS));
  assign bin_val = valid[rd_bin] ? ram_rdata : '0;
  assign run_sum = {1'b0, running} + {1'b0, bin_val};
  assign hit     = (run_sum > {1'b0, quota});

  always_comb begin
    state_next = state;
    unique case (state)
      ST_RUN: begin
        if (take && (op.kind == OP_ACC_WALK)) begin
          state_next = ST_QMUL;
        end
      end
      ST_QMUL:   state_next = ST_QSCALE;
      ST_QSCALE: state_next = ST_WALK;
      ST_WALK: begin
        if (rd_pend && (hit || (rd_bin == LAST_BIN))) begin
          state_next = ST_RUN;
        end
      end
      default: state_next = ST_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_RUN;
      total     <= '0;
      valid     <= '0;
      threshold <= '0;
      s2_valid  <= 1'b0;
      w_valid   <= 1'b0;
      rd_pend   <= 1'b0;
      wcnt      <= '0;
    end else begin
      state    <= state_next;
      s2_valid <= counted;
      w_valid  <= s2_valid;
      if (counted) begin
        total <= total + 1'b1;
      end
      // frame clear wins over a write still draining
      if (clear) begin
        valid <= '0;
        total <= '0;
      end else if (s2_valid) begin
        valid[s2_bin] <= 1'b1;
      end
      if (state == ST_QSCALE) begin
        wcnt    <= '0;
        rd_pend <= 1'b0;
      end else if (state == ST_WALK) begin
        rd_pend <= wmore;
        if (wmore) begin
          wcnt <= wcnt + 1'b1;
        end
        if (rd_pend) begin
          if (hit) begin
            threshold <= thr_of(rd_bin);
          end else if (rd_bin == LAST_BIN) begin
            threshold <= THR_NONE;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    s2_bin <= op.bin;
    w_bin  <= s2_bin;
    w_data <= ram_wdata;
    rd_bin <= wcnt[BIN_W-1:0];
    if (state == ST_QMUL) begin
      prod <= total * pct;
    end
    if (state == ST_QSCALE) begin
      qm      <= prod * RECIP;
      running <= '0;
    end else if ((state == ST_WALK) && rd_pend) begin
      running <= run_sum[CNT_W-1:0];
    end
  end

  assign stat.walking  = (state == ST_WALK);
  assign stat.acc_busy = s2_valid;

endmodule

@@ rtl/core/ptb_resq.sv @@
// ptb_resq: result queue that decouples the back end from the consumer.
// Depends on ptb_pkg.
module ptb_resq import ptb_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  res_t din,
  input  logic pop,
  output logic empty,
  output res_t dout
);

  res_t               q [RESQ_DEPTH];
  logic [RESQ_AW-1:0] wp, rp;
  logic [RESQ_AW:0]   cnt;
  logic               wr, rd;

  assign full  = (cnt == (RESQ_AW+1)'(RESQ_DEPTH));
  assign empty = (cnt == '0);
  assign dout  = q[rp];
  assign wr    = push && !full;
  assign rd    = pop && !empty;

  always_ff @(posedge clk) begin
    if (wr) begin
      q[wp] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (wr) begin
        wp <= wp + 1'b1;
      end
      if (rd) begin
        rp <= rp + 1'b1;
      end
      case ({wr, rd})
        2'b10:   cnt <= cnt + 1'b1;
        2'b01:   cnt <= cnt - 1'b1;
        default: cnt <= cnt;
      endcase
    end
  end

endmodule

@@ rtl/core/ptb_threshold_binarizer_top_note.sv @@
// ptb_cfg: black percentage register behind the configuration write channel.
// Depends on ptb_pkg.
module ptb_cfg import ptb_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [PCT_W-1:0] cfg_data,
  output logic [PCT_W-1:0] black_percent
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      black_percent <= PCT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      black_percent <= cfg_data;
    end
  end

endmodule

@@ rtl/core/ptile_threshold_binarizer.sv @@
// ptile_threshold_binarizer: p-tile threshold binarizer, top level.
// Classify words reach the result ports through the op queue and the result queue.
// Throughput: 1 word per cycle; an accumulate word marked frame_end adds a quota step and a
//   bin walk (one histogram RAM read a cycle), and a full result queue holds classify words.
// Reset (rst, synchronous): queues empty, histogram and count cleared, threshold 0,
//   black_percent 50. No clearing pass: per-bin valid bits drop at once.
module ptile_threshold_binarizer import ptb_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  // pixel input queue
  input  logic             push,
  output logic             full,
  input  logic             req_type,
  input  logic [PIX_W-1:0] pixel,
  input  logic             frame_end,
  // result queue
  output logic             empty,
  input  logic             pop,
  output logic             binary,
  output logic [THR_W-1:0] threshold_used,
  output logic             last,
  // configuration write channel (black_percent)
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [PCT_W-1:0] cfg_data
);

  op_t              op;
  logic             op_valid;
  logic             op_take;
  res_t             res_in;
  res_t             res_out;
  logic             res_push;
  logic             res_full;
  bk_stat_t         stat;
  logic [PCT_W-1:0] black_percent;

  // Percentage register; the user is to write it only while the block is idle (not enforced here).
  ptb_cfg u_cfg (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .black_percent (black_percent)
  );

  // Front: decode pixel words into operations and buffer them.
  ptb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .req_type  (req_type),
    .pixel     (pixel),
    .frame_end (frame_end),
    .op        (op),
    .op_valid  (op_valid),
    .op_take   (op_take)
  );

  // Back: histogram, quota/walk and classification. Stalls the op queue during the
  // quota step and the walk, and holds classify ops whenever the result queue is full.
  ptb_back u_back (
    .clk           (clk),
    .rst           (rst),
    .black_percent (black_percent),
    .op            (op),
    .op_valid      (op_valid),
    .op_take       (op_take),
    .res_push      (res_push),
    .res           (res_in),
    .res_full      (res_full),
    .stat          (stat)
  );

  // Result queue to the consumer.
  ptb_resq u_resq (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .full  (res_full),
    .din   (res_in),
    .pop   (pop),
    .empty (empty),
    .dout  (res_out)
  );

  assign binary         = res_out.binary;
  assign threshold_used = res_out.thr;
  assign last           = res_out.last;

  // a result is only produced when the result queue has room
  a_res_room: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result pushed into full queue");

  // no operation leaves the op queue during a bin walk
  a_walk_hold: assert property (@(posedge clk) disable iff (rst)
    stat.walking |-> !op_take)
    else $error("op taken during walk");

  // the last histogram write has drained before the walk reads bins
  a_walk_drained: assert property (@(posedge clk) disable iff (rst)
    stat.walking |-> !stat.acc_busy)
    else $error("histogram write pending during walk");

  // an op is taken only when the op queue holds one
  a_take_valid: assert property (@(posedge clk) disable iff (rst)
    op_take |-> op_valid)
    else $error("op taken from empty queue");

endmodule

@@ bench/tb.sv @@
// tb: self-checking bench for ptile_threshold_binarizer (p-tile frame binarizer).
// Depends on ptb_pkg for widths, MAX_PIXELS, LEVELS and the res_t result word.
// Tracks histogram, pixel count and threshold on its own and checks each result word.
module tb;
  import ptb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // input word kinds
  typedef enum logic {
    REQ_ACC = 1'b0,   // add pixel to histogram
    REQ_CLS = 1'b1    // classify pixel against threshold
  } req_t;

  // one row of the directed table; want is only used when typed is set
  typedef struct packed {
    req_t             req;
    logic [PIX_W-1:0] pix;
    logic             fend;
    logic             typed;
    res_t             want;
  } dir_row_t;

  localparam int N_DIRECTED   = 22;
  // room for every queued walk to run out, plus pipe
  localparam int SETTLE_CYCLES = (OPQ_DEPTH + 1) * (LEVELS + 8);
  localparam int CYCLE_LIMIT  = 2000000;
  localparam int STALL_PCT    = 16;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             push = 1'b0;
  logic             full;
  logic             req_type = 1'b0;
  logic [PIX_W-1:0] pixel = '0;
  logic             frame_end = 1'b0;
  logic             empty;
  logic             pop = 1'b0;
  logic             binary;
  logic [THR_W-1:0] threshold_used;
  logic             last;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [PCT_W-1:0] cfg_data = '0;

  ptile_threshold_binarizer u_top (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .req_type       (req_type),
    .pixel          (pixel),
    .frame_end      (frame_end),
    .empty          (empty),
    .pop            (pop),
    .binary         (binary),
    .threshold_used (threshold_used),
    .last           (last),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  // shadow of the block state: histogram, pixel count, threshold, percent
  logic [CNT_W-1:0] hist_bins [LEVELS];
  logic [CNT_W-1:0] px_total;
  logic [THR_W-1:0] thr_cur;
  logic [PCT_W-1:0] pct_cur;

  // classification words owed by the block, oldest first
  res_t pending_class [$];

  int unsigned errors;
  int unsigned words_sent;
  int unsigned results_checked;
  int unsigned cfg_writes;
  int unsigned cycles;
  bit          no_stall;   // set for long stretches where neither side idles

  dir_row_t directed_rows [N_DIRECTED];

  // 12 ns clock
  initial begin
    forever #6 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d classification words still owed", $time,
               pending_class.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // Result side: pop at random, check each popped word against the oldest owed one.
  // Values read right after the edge are the ones the edge sampled.
  initial begin
    res_t want;
    forever begin
      @(posedge clk);
      if (!rst && pop && !empty) begin
        if (pending_class.size() == 0) begin
          $display("%0t: unexpected result word: binary %0d threshold %0d last %0d",
                   $time, binary, threshold_used, last);
          errors++;
        end else begin
          want = pending_class.pop_front();
          results_checked++;
          if (binary !== want.binary) begin
            $display("%0t: binary expected %0d got %0d", $time, want.binary, binary);
            errors++;
          end
          if (threshold_used !== want.thr) begin
            $display("%0t: threshold_used expected %0d got %0d", $time, want.thr,
                     threshold_used);
            errors++;
          end
          if (last !== want.last) begin
            $display("%0t: last expected %0d got %0d", $time, want.last, last);
            errors++;
          end
        end
      end
      pop <= !rst && (no_stall || ($urandom_range(0, 99) >= STALL_PCT));
    end
  end

  // Threshold walk: quota = floor(count * pct / 100), first bin whose running sum
  // passes it, 255 when none does. Percent above 100 acts as 100.
  function automatic void walk_bins();
    int unsigned pct;
    int unsigned quota;
    int unsigned running;
    bit          hit;
    pct     = (pct_cur > PCT_MAX) ? 100 : int'(pct_cur);
    quota   = (int'(px_total) * pct) / 100;
    running = 0;
    hit     = 1'b0;
    thr_cur = THR_NONE;
    for (int b = 0; b < LEVELS; b++) begin
      running += hist_bins[b];
      if (!hit && running > quota) begin
        thr_cur = THR_W'(b);
        hit     = 1'b1;
      end
    end
  endfunction

  // Push one word, idling at random first; push stays high into the next call so it
  // never drops and rises in one step. On accept, update the shadow state.
  task automatic send_word(input req_t r, input logic [PIX_W-1:0] p, input logic f,
                           input bit typed = 1'b0, input res_t typed_want = '0);
    res_t nxt;
    while (!no_stall && $urandom_range(0, 99) < STALL_PCT) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push      <= 1'b1;
    req_type  <= r;
    pixel     <= p;
    frame_end <= f;
    do @(posedge clk); while (full);
    words_sent++;
    if (r == REQ_CLS) begin
      nxt.binary = (p > thr_cur);
      nxt.thr    = thr_cur;
      nxt.last   = f;
      pending_class.push_back(typed ? typed_want : nxt);
      if (f) begin
        foreach (hist_bins[i]) hist_bins[i] = '0;
        px_total = '0;
      end
    end else begin
      // count saturates at MAX_PIXELS; the frame_end mark still walks
      if (int'(px_total) < MAX_PIXELS) begin
        hist_bins[p] = hist_bins[p] + 1'b1;
        px_total     = px_total + 1'b1;
      end
      if (f) walk_bins();
    end
  endtask

  // Wait until every owed word has come back, then let any walk run out.
  task automatic drain();
    push <= 1'b0;
    while (pending_class.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_percent(input logic [PCT_W-1:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    pct_cur = v;
    cfg_writes++;
  endtask

  function automatic logic [PIX_W-1:0] pick_pixel(input int base, input int spread);
    int v;
    v = base - spread + int'($urandom_range(0, 2 * spread));
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return PIX_W'(v);
  endfunction

  task automatic send_pass(input req_t r, input int n, input int base, input int spread,
                           input bit mark_end);
    for (int i = 0; i < n; i++) begin
      send_word(r, pick_pixel(base, spread), mark_end && (i == n - 1));
    end
  endtask

  // Mostly whole frames (accumulate pass then classify pass), the rest
  // accumulate-only frames, stray classify runs and single random words.
  task automatic run_random(input int budget);
    int unsigned start;
    int          pick;
    int          n;
    int          base;
    int          spread;
    start = words_sent;
    while (words_sent - start < budget) begin
      pick = $urandom_range(0, 99);
      base = $urandom_range(0, 255);
      case ($urandom_range(0, 3))
        0: spread = 0;
        1: spread = 4;
        2: spread = 40;
        default: spread = 255;
      endcase
      n = ($urandom_range(0, 19) == 0) ? $urandom_range(25, 120) : $urandom_range(1, 16);
      if (pick < 70) begin
        send_pass(REQ_ACC, n, base, spread, 1'b1);
        // classify around the new threshold half the time
        if ($urandom_range(0, 1)) begin
          send_pass(REQ_CLS, $urandom_range(1, 16), int'(thr_cur), 2, 1'b1);
        end else begin
          send_pass(REQ_CLS, $urandom_range(1, 16), base, spread, 1'b1);
        end
      end else if (pick < 80) begin
        send_pass(REQ_ACC, n, base, spread, 1'($urandom_range(0, 1)));
      end else if (pick < 90) begin
        send_pass(REQ_CLS, n, base, spread, 1'($urandom_range(0, 1)));
      end else begin
        send_word(req_t'($urandom_range(0, 1)), PIX_W'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)));
      end
    end
  endtask

  // Stimulus
  initial begin
    logic [PCT_W-1:0] pct_plan [9];
    foreach (hist_bins[i]) hist_bins[i] = '0;
    px_total = '0;
    thr_cur  = '0;
    pct_cur  = PCT_RESET;

    // directed rows; results typed in where they are obvious
    directed_rows = '{
      // classify before any walk: threshold is 0 after reset
      '{REQ_CLS, 8'd0,    1'b0, 1'b1, '{1'b0, 8'd0,   1'b0}},
      '{REQ_CLS, 8'd255,  1'b1, 1'b1, '{1'b1, 8'd0,   1'b1}},
      // two-pixel frame at the extremes: quota 1, so the walk lands on 255
      '{REQ_ACC, 8'd0,    1'b0, 1'b0, '0},
      '{REQ_ACC, 8'd255,  1'b1, 1'b0, '0},
      '{REQ_CLS, 8'd255,  1'b0, 1'b1, '{1'b0, 8'd255, 1'b0}},
      '{REQ_CLS, 8'd0,    1'b1, 1'b1, '{1'b0, 8'd255, 1'b1}},
      // one-pixel frame: quota 0, threshold is that pixel
      '{REQ_ACC, 8'd128,  1'b1, 1'b0, '0},
      '{REQ_CLS, 8'd128,  1'b0, 1'b1, '{1'b0, 8'd128, 1'b0}},
      '{REQ_CLS, 8'd129,  1'b0, 1'b1, '{1'b1, 8'd128, 1'b0}},
      '{REQ_CLS, 8'd127,  1'b1, 1'b1, '{1'b0, 8'd128, 1'b1}},
      // four-pixel frame, then a second accumulate frame adding to it
      '{REQ_ACC, 8'd10,   1'b0, 1'b0, '0},
      '{REQ_ACC, 8'd20,   1'b0, 1'b0, '0},
      '{REQ_ACC, 8'd30,   1'b0, 1'b0, '0},
      '{REQ_ACC, 8'd40,   1'b1, 1'b0, '0},
      '{REQ_ACC, 8'd200,  1'b1, 1'b0, '0},
      '{REQ_CLS, 8'd31,   1'b0, 1'b0, '0},
      '{REQ_CLS, 8'd30,   1'b0, 1'b0, '0},
      '{REQ_CLS, 8'd200,  1'b1, 1'b0, '0},
      // alternating bit patterns
      '{REQ_ACC, 8'hAA,   1'b0, 1'b0, '0},
      '{REQ_ACC, 8'h55,   1'b1, 1'b0, '0},
      '{REQ_CLS, 8'h55,   1'b0, 1'b0, '0},
      '{REQ_CLS, 8'hAA,   1'b1, 1'b0, '0}
    };

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_word(directed_rows[i].req, directed_rows[i].pix, directed_rows[i].fend,
                directed_rows[i].typed, directed_rows[i].want);
    end

    // percent settings: extremes, values above 100, reset value, two random ones
    pct_plan = '{PCT_W'(0), PCT_MAX, PCT_W'(127), PCT_W'(101), PCT_W'(1), PCT_W'(99),
                 PCT_RESET, PCT_W'($urandom_range(0, 127)), PCT_W'($urandom_range(0, 127))};
    foreach (pct_plan[i]) begin
      write_percent(pct_plan[i]);
      no_stall = (pct_plan[i] == PCT_W'(99));   // a long stretch without idling
      run_random(70);
      no_stall = 1'b0;
    end

    drain();
    $display("Covered %0d input words, %0d result words checked, %0d percent writes,",
             words_sent, results_checked, cfg_writes);
    $display("directed edge frames, empty-quota and above-100 percent settings.");
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
